// ----- design/mcbm_pkg.sv -----
// Package for the multicart bank mapper.
// Holds the mapping record, the result record and the address page codes.
// No dependencies.
package mcbm_pkg;

    // Widths of the item fields.
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int BANK_W = 16;
    localparam int NUM_WIN = 4;

    // Packed stream widths: address and data, and banks, RAM mask, mirroring.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 72;

    // Values of address bits 15:12 that select the address-driven modes.
    localparam logic [3:0] PAGE_A = 4'hA;
    localparam logic [3:0] PAGE_C = 4'hC;
    localparam logic [3:0] PAGE_D = 4'hD;
    localparam logic [3:0] PAGE_E = 4'hE;

    // Submapper mode codes.
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_ADDR = 1'b1;

    // Decoded mapping.
    typedef struct packed {
        logic                            mirror_h;
        logic [NUM_WIN-1:0]              ram_mask;
        logic [NUM_WIN-1:0][BANK_W-1:0]  bank;
    } t_map;

    // One result item.
    typedef struct packed {
        logic latched;
        t_map map;
    } t_result;

endpackage

// ----- design/mcbm_decode.sv -----
// Mapping decoder of the multicart bank mapper.
// Turns the address and data latches and the submapper mode into a mapping.
// Depends on mcbm_pkg.
module mcbm_decode
    import mcbm_pkg::*;
(
    input  logic              i_mode,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_data,
    output t_map              o_map
);

    logic [14:0] b;
    logic [1:0]  rw;
    logic [1:0]  dw;
    logic [14:0] e;

    assign b  = i_addr[15:1];
    assign rw = i_addr[10:9];
    assign dw = i_data[5:4];
    assign e  = {b[14:1], 1'b0};

    // Decode rules for both board variants.
    always_comb begin
        o_map = '0;
        if (i_mode == MODE_ADDR) begin
            // Low 16K takes the address bank; page D sets every window to the full address.
            o_map.bank[0] = {b, 1'b0};
            o_map.bank[1] = {b, 1'b1};
            o_map.bank[2] = 16'd0;
            o_map.bank[3] = 16'd1;
            case (i_addr[15:12])
                PAGE_A: begin
                    o_map.ram_mask = 4'b0001 << rw;
                end
                PAGE_C: begin
                    o_map.bank[2] = {b[14:1], 2'b10};
                    o_map.bank[3] = {b[14:1], 2'b11};
                    o_map.ram_mask = 4'b0001 << rw;
                end
                PAGE_D: begin
                    o_map.bank[0] = i_addr;
                    o_map.bank[1] = i_addr;
                    o_map.bank[2] = i_addr;
                    o_map.bank[3] = i_addr;
                    o_map.ram_mask = i_addr[9] ? 4'b1010 : 4'b0101;
                end
                PAGE_E: begin
                    if (i_addr[8]) begin
                        o_map.bank[2] = {b[14:3], 4'b1110};
                        o_map.bank[3] = {b[14:3], 4'b1111};
                    end
                    o_map.ram_mask = 4'b0001 << rw;
                end
                default: begin
                    o_map.ram_mask = 4'b0000;
                end
            endcase
            o_map.mirror_h = i_addr[11];
        end else begin
            if (i_data[1]) begin
                // 8K bank in all windows, RAM in two windows.
                o_map.bank[0] = {1'b0, b};
                o_map.bank[1] = {1'b0, b};
                o_map.bank[2] = {1'b0, b};
                o_map.bank[3] = {1'b0, b};
                o_map.ram_mask = (4'b0001 << (dw ^ 2'b10)) | (4'b0001 << dw);
            end else if (i_data[3]) begin
                // Four consecutive 8K banks; data bit 2 is ORed into bit 2 of the last one.
                o_map.bank[0] = {1'b0, e};
                o_map.bank[1] = {1'b0, e[14:1], 1'b1};
                o_map.bank[2] = {1'b0, e[14:2], 2'b10};
                o_map.bank[3] = {1'b0, e[14:3], e[2] | i_data[2], 2'b11};
                o_map.ram_mask = 4'b0001 << dw;
            end else begin
                // 16K bank from address bits 15:2, second half bank 0.
                o_map.bank[0] = {1'b0, i_addr[15:2], 1'b0};
                o_map.bank[1] = {1'b0, i_addr[15:2], 1'b1};
                o_map.bank[2] = 16'd0;
                o_map.bank[3] = 16'd1;
                o_map.ram_mask = 4'b0001 << dw;
            end
            o_map.mirror_h = i_data[0];
        end
    end

endmodule

// ----- design/mcbm_core.sv -----
// Latch stage of the multicart bank mapper.
// Holds the mode register and the address and data latches, decides RAM hits
// and produces the mapping after each item. Depends on mcbm_pkg, mcbm_decode.
module mcbm_core
    import mcbm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_accept,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_data,
    output t_result           o_result
);

    logic              r_mode;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;
    logic [ADDR_W-1:0] n_addr;
    logic [DATA_W-1:0] n_data;
    t_map              cur_map;
    t_map              next_map;
    logic              ram_hit;

    // Mapping that holds before this item.
    mcbm_decode u_dec_cur (
        .i_mode (r_mode),
        .i_addr (r_addr),
        .i_data (r_data),
        .o_map  (cur_map)
    );

    // A write into a RAM-overlaid window leaves the latches alone.
    assign ram_hit = cur_map.ram_mask[i_addr[14:13]];
    assign n_addr  = ram_hit ? r_addr : i_addr;
    assign n_data  = ram_hit ? r_data : i_data;

    // Mapping after this item.
    mcbm_decode u_dec_next (
        .i_mode (r_mode),
        .i_addr (n_addr),
        .i_data (n_data),
        .o_map  (next_map)
    );

    assign o_result.latched = ~ram_hit;
    assign o_result.map     = next_map;

    // Mode register and latches.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DATA;
            r_addr <= '0;
            r_data <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_addr <= n_addr;
                r_data <= n_data;
            end
        end
    end

endmodule

// ----- design/multicart_bank_mapper.sv -----
// Top level of the multicart bank mapper.
// Depends on mcbm_pkg and mcbm_core (which uses mcbm_decode).
//
// Usage: each CPU write to 0x8000-0xFFFF enters as one item on the slave
// stream (address and data in tdata). For every item one result item leaves
// on the master stream: the four 8K bank numbers, the work RAM window mask and
// the mirroring that hold after the write, with tuser set when the write
// updated the mapper latches and clear when it went to work RAM.
// The user must write the submapper mode through i_cfg_wr_en/i_cfg_wr_data
// only while the stream is idle; the block does not enforce this.
// The result is registered and is valid in the cycle after input accept.
// Throughput is one item per cycle unless the receiver stalls: the RAM hit
// check, latch update and decode all happen in the cycle the item is accepted.
// Reset clears the latches and the mode and empties the result register.
// When the receiver stalls, the result is held and a new item is accepted
// only in a cycle where the held result is taken.
module multicart_bank_mapper
    import mcbm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration: submapper_mode.
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    // Input items.
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata: write_address[15:0], write_data[23:16].
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // Result items.
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata: bank_window0[15:0], bank_window1[31:16], bank_window2[47:32],
    // bank_window3[63:48], ram_window_mask[67:64], mirror_horizontal[68], zero pad.
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: write_latched[0].
    output logic                 o_m_axis_tuser
);

    logic    r_valid;
    t_result r_result;
    t_result n_result;
    logic    accept;

    // The result register can load when empty or being drained.
    assign o_s_axis_tready = ~r_valid | i_m_axis_tready;
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;

    mcbm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_addr        (i_s_axis_tdata[15:0]),
        .i_data        (i_s_axis_tdata[23:16]),
        .o_result      (n_result)
    );

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tuser  = r_result.latched;
    assign o_m_axis_tdata  = {3'b000, r_result.map};

endmodule

// ----- design/mcbm_checker.sv -----
// Port-level checker for the multicart bank mapper, bound to the top level.
// Depends on mcbm_pkg for the stream widths.
module mcbm_checker
    import mcbm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                 o_m_axis_tuser
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // An accepted item shows a result on the next cycle.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> o_m_axis_tvalid)
        else $error("accepted item gave no result");

    // The block never refuses an item while its result register is empty.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("not ready while empty");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind multicart_bank_mapper mcbm_checker u_mcbm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
